// ----- rtl/core/me_pkg.sv -----
`timescale 1ns / 1ps

package me_pkg;

    // field width of base, exponent, modulus and result words
    localparam int FIELD_W = 32;

    // apb byte address width, word index in bit 2
    localparam int PADDR_W = 3;

    // word index of the modulus register
    localparam logic REG_MODULUS = 1'b0;

    localparam logic [FIELD_W-1:0] MODULUS_RESET = 32'd1;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_stat;

endpackage

// ----- rtl/core/modular_exponentiation_top.sv -----
`timescale 1ns / 1ps
// channel   | valid       | ready       | payload
// in        | i_in_valid  | o_in_ready  | i_base_value, i_exponent
// out       | o_out_valid | i_out_ready | o_result
// config    | psel/penable/pwrite | pready | paddr, pwdata, prdata
//
// one word at a time; a taken zero exponent sets r_pend, then moves on to the output register
// otherwise the shared bit-serial modular multiplier makes one base
// reduction, one multiply per set exponent bit and one squaring per bit below the top set bit,
// with one pass through the decision state S_NEXT per exponent bit
// synchronous active-low reset clears control state and sets modulus to 1
// a finished word waits in the output register; the next input word is taken meanwhile

module modular_exponentiation_top #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [me_pkg::FIELD_W-1:0]  i_base_value,
    input  logic [me_pkg::FIELD_W-1:0]  i_exponent,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [me_pkg::FIELD_W-1:0]  o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [me_pkg::PADDR_W-1:0]  paddr,
    input  logic [me_pkg::FIELD_W-1:0]  pwdata,
    output logic [me_pkg::FIELD_W-1:0]  prdata,
    output logic                        pready
);
    import me_pkg::*;

    localparam int W = OPERAND_WIDTH;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RED  = 5'b00010,
        S_NEXT = 5'b00100,
        S_MUL  = 5'b01000,
        S_SQR  = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [W-1:0]       r_acc;
    logic [W-1:0]       r_x;
    logic [W-1:0]       r_e;
    logic               r_pend;
    logic               r_out_valid;
    logic [FIELD_W-1:0] r_res;

    logic [FIELD_W-1:0] w_modulus;
    logic [W-1:0]       w_m;
    logic               w_in_acc;
    logic               w_out_free;
    logic               w_start;
    logic [W-1:0]       w_a, w_b, w_p;
    t_mul_stat          w_stat;

    me_apb u_apb (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_modulus (w_modulus)
    );

    assign w_m = W'(w_modulus);

    me_mulmod #(.W(W)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_m     (w_m),
        .o_p     (w_p),
        .o_stat  (w_stat)
    );

    // a finished result may only sit in r_acc until the output register frees
    assign o_in_ready = (r_state == S_IDLE) && !r_pend;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        w_start = 1'b0;
        w_a     = r_x;
        w_b     = r_x;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && (W'(i_exponent) != '0)) begin
                    // base mod m as 1 * base
                    w_start = 1'b1;
                    w_a     = W'(1);
                    w_b     = W'(i_base_value);
                    n_state = S_RED;
                end
            end
            S_RED: begin
                if (w_stat.done) begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (r_e[0]) begin
                    w_start = 1'b1;
                    w_a     = r_acc;
                    n_state = S_MUL;
                end else begin
                    w_start = 1'b1;
                    n_state = S_SQR;
                end
            end
            S_MUL: begin
                if (w_stat.done) begin
                    if (r_e[W-1:1] != '0) begin
                        w_start = 1'b1;
                        n_state = S_SQR;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SQR: begin
                if (w_stat.done) begin
                    n_state = S_NEXT;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_pend && w_out_free) begin
                r_out_valid <= 1'b1;
                r_pend      <= 1'b0;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_in_acc && (W'(i_exponent) == '0)) begin
                r_pend <= 1'b1;
            end else if (r_state == S_MUL && w_stat.done && (r_e[W-1:1] == '0)) begin
                r_pend <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_acc <= W'(1);
            r_e   <= W'(i_exponent);
        end
        if (r_pend && w_out_free) begin
            r_res <= FIELD_W'(r_acc);
        end
        case (r_state)
            S_RED: begin
                if (w_stat.done) begin
                    r_x <= w_p;
                end
            end
            S_NEXT: begin
                if (!r_e[0]) begin
                    r_e <= r_e >> 1;
                end
            end
            S_MUL: begin
                if (w_stat.done) begin
                    r_acc <= w_p;
                    r_e   <= r_e >> 1;
                end
            end
            S_SQR: begin
                if (w_stat.done) begin
                    r_x <= w_p;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_res;

endmodule

// ----- rtl/core/me_apb.sv -----
`timescale 1ns / 1ps

module me_apb (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [me_pkg::PADDR_W-1:0]  paddr,
    input  logic [me_pkg::FIELD_W-1:0]  pwdata,
    output logic [me_pkg::FIELD_W-1:0]  prdata,
    output logic                        pready,
    output logic [me_pkg::FIELD_W-1:0]  o_modulus
);
    import me_pkg::*;

    logic [FIELD_W-1:0] r_modulus;
    logic               w_sel_mod;

    assign w_sel_mod = (paddr[PADDR_W-1] == REG_MODULUS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MODULUS_RESET;
        end else if (psel && penable && pwrite && w_sel_mod) begin
            r_modulus <= pwdata;
        end
    end

    assign prdata    = w_sel_mod ? r_modulus : '0;
    assign pready    = 1'b1;
    assign o_modulus = r_modulus;

endmodule

// ----- rtl/core/me_mulmod.sv -----
`timescale 1ns / 1ps

module me_mulmod #(
    parameter int W = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [W-1:0]       i_a,
    input  logic [W-1:0]       i_b,
    input  logic [W-1:0]       i_m,
    output logic [W-1:0]       o_p,
    output me_pkg::t_mul_stat  o_stat
);
    import me_pkg::*;

    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     r_acc, n_acc;
    logic [W-1:0]     r_a;
    logic [W-1:0]     r_b;
    logic [W-1:0]     r_m;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [W+1:0] w_t, w_m1, w_m2, w_s1, w_s2;

    // interleaved step: acc = 2*acc + bit*a, then pull back below m
    assign w_t  = {1'b0, r_acc, 1'b0} + (r_b[W-1] ? {2'b00, r_a} : '0);
    assign w_m1 = {2'b00, r_m};
    assign w_m2 = {1'b0, r_m, 1'b0};
    assign w_s1 = w_t - w_m1;
    assign w_s2 = w_t - w_m2;

    always_comb begin
        if (r_m == '0) begin
            // modulus zero wraps at the datapath width
            n_acc = w_t[W-1:0];
        end else if (w_t >= w_m2) begin
            n_acc = w_s2[W-1:0];
        end else if (w_t >= w_m1) begin
            n_acc = w_s1[W-1:0];
        end else begin
            n_acc = w_t[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
            r_m   <= i_m;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= {r_b[W-2:0], 1'b0};
        end
    end

    assign o_p         = r_acc;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

// ----- rtl/core/me_checker.sv -----
`timescale 1ns / 1ps

module me_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        o_in_ready,
    input  logic                        o_out_valid,
    input  logic                        i_out_ready,
    input  logic [me_pkg::FIELD_W-1:0]  o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [me_pkg::PADDR_W-1:0]  paddr,
    input  logic [me_pkg::FIELD_W-1:0]  pwdata,
    input  logic [me_pkg::FIELD_W-1:0]  prdata,
    input  logic                        pready
);
    import me_pkg::*;

    // a waiting result word holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_result)))
        else $error("output word changed while stalled");

    // only one word in flight
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while a word is in flight");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready dropped");

    // modulus readback follows the last write
    a_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((psel && penable && pwrite && (paddr[PADDR_W-1] == REG_MODULUS)) ##1
         (paddr[PADDR_W-1] == REG_MODULUS)) |-> (prdata == $past(pwdata)))
        else $error("modulus readback mismatch");

endmodule

bind modular_exponentiation_top me_checker u_me_checker (.*);

// ----- tb/modexp_result_checker.sv -----
`timescale 1ns / 1ps

module modexp_result_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic [me_pkg::FIELD_W-1:0] i_base_value,
    input  logic [me_pkg::FIELD_W-1:0] i_exponent,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic [me_pkg::FIELD_W-1:0] i_result,
    input  logic                       i_psel,
    input  logic                       i_penable,
    input  logic                       i_pwrite,
    input  logic [me_pkg::PADDR_W-1:0] i_paddr,
    input  logic [me_pkg::FIELD_W-1:0] i_pwdata,
    input  logic [me_pkg::FIELD_W-1:0] i_prdata,
    input  logic                       i_pready,
    output int                         o_pending,
    output int                         o_mismatches
);
    import me_pkg::*;

    logic [FIELD_W-1:0] modulus_copy = MODULUS_RESET;
    logic [FIELD_W-1:0] expected_powers[$];
    logic [FIELD_W-1:0] oldest_power;
    int                 powers_pending = 0;
    int                 mismatch_count = 0;

    assign o_pending    = powers_pending;
    assign o_mismatches = mismatch_count;

    // exact double-width product, modulus zero means plain wrap to the field width
    function automatic logic [63:0] mul_reduce(input logic [63:0] a, input logic [63:0] b,
                                               input logic [FIELD_W-1:0] m);
        logic [63:0] prod;
        prod = a * b;
        if (m == '0)
            return {32'd0, prod[FIELD_W-1:0]};
        return prod % {32'd0, m};
    endfunction

    // right-to-left square and multiply
    function automatic logic [FIELD_W-1:0] power_mod(input logic [FIELD_W-1:0] b,
                                                     input logic [FIELD_W-1:0] e,
                                                     input logic [FIELD_W-1:0] m);
        logic [63:0]        sq;
        logic [63:0]        acc;
        logic [FIELD_W-1:0] bits_left;
        if (e == '0)
            return 1;
        sq = {32'd0, b};
        if (m != '0)
            sq = sq % {32'd0, m};
        acc = (m == 1) ? 64'd0 : 64'd1;
        bits_left = e;
        while (bits_left != '0) begin
            if (bits_left[0])
                acc = mul_reduce(acc, sq, m);
            bits_left = bits_left >> 1;
            sq = mul_reduce(sq, sq, m);
        end
        return acc[FIELD_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            modulus_copy = MODULUS_RESET;
            expected_powers.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_powers.size() == 0) begin
                    $error("result: no word expected, actual %h", i_result);
                    mismatch_count++;
                end else begin
                    oldest_power = expected_powers.pop_front();
                    if (i_result !== oldest_power) begin
                        $error("result: expected %h, actual %h", oldest_power, i_result);
                        mismatch_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                expected_powers.push_back(power_mod(i_base_value, i_exponent, modulus_copy));
            if (i_psel && i_penable && i_pready && i_paddr[2] == REG_MODULUS) begin
                if (i_pwrite) begin
                    modulus_copy = i_pwdata;
                end else if (i_prdata !== modulus_copy) begin
                    $error("modulus: expected %h, actual %h", modulus_copy, i_prdata);
                    mismatch_count++;
                end
            end
        end
        powers_pending = expected_powers.size();
    end

endmodule

// ----- tb/modular_exponentiation_top_tb.sv -----
`timescale 1ns / 1ps

module modular_exponentiation_top_tb;
    import me_pkg::*;

    localparam int                 RECEIVER_HOLD = 8000;
    localparam logic [PADDR_W-1:0] MODULUS_ADDR  = {REG_MODULUS, 2'b00};
    localparam logic [FIELD_W-1:0] PRIME_MAX     = 32'hFFFF_FFFB;
    localparam logic [FIELD_W-1:0] ALL_ONES      = 32'hFFFF_FFFF;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_in_valid   = 1'b0;
    logic               o_in_ready;
    logic [FIELD_W-1:0] i_base_value = '0;
    logic [FIELD_W-1:0] i_exponent   = '0;
    logic               o_out_valid;
    logic               i_out_ready  = 1'b0;
    logic [FIELD_W-1:0] o_result;
    logic               psel         = 1'b0;
    logic               penable      = 1'b0;
    logic               pwrite       = 1'b0;
    logic [PADDR_W-1:0] paddr        = '0;
    logic [FIELD_W-1:0] pwdata       = '0;
    logic [FIELD_W-1:0] prdata;
    logic               pready;

    logic               hold_off_req = 1'b0;
    logic               no_gaps      = 1'b0;
    logic [FIELD_W-1:0] cur_modulus  = MODULUS_RESET;
    int                 pending;
    int                 mismatches;

    always #5 i_clk = ~i_clk;

    modular_exponentiation_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_base_value (i_base_value),
        .i_exponent   (i_exponent),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_result     (o_result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    modexp_result_checker u_result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_base_value (i_base_value),
        .i_exponent   (i_exponent),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_result     (o_result),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 25);
        return $urandom_range(60, 400);
    endfunction

    function automatic logic [FIELD_W-1:0] pick_base();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 1;
            2: return ALL_ONES;
            3: return cur_modulus - 1;
            4: return cur_modulus;
            default: return $urandom;
        endcase
    endfunction

    // mostly short exponents to keep the run short, some full width
    function automatic logic [FIELD_W-1:0] pick_exponent();
        int                 nbits;
        logic [FIELD_W-1:0] e;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return $urandom;
            2: return ALL_ONES;
            default: begin
                nbits = $urandom_range(1, 12);
                e = $urandom & ((32'd1 << nbits) - 1);
                return e | (32'd1 << (nbits - 1));
            end
        endcase
    endfunction

    // called at a falling edge; the caller sends again or drops valid in the same step
    task automatic send_word(input logic [FIELD_W-1:0] b, input logic [FIELD_W-1:0] e);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_base_value <= b;
        i_exponent   <= e;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [FIELD_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= MODULUS_ADDR;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // write then read back, only with nothing in flight
    task automatic set_modulus(input logic [FIELD_W-1:0] m);
        wait_idle();
        apb_access(1'b1, m);
        apb_access(1'b0, '0);
        cur_modulus = m;
    endtask

    // output side: random stalls, plus one long hold-off on request
    initial begin
        int r;
        @(negedge i_clk);
        forever begin
            if (hold_off_req) begin
                i_out_ready <= 1'b0;
                repeat (RECEIVER_HOLD) @(negedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    i_out_ready <= 1'b1;
                    repeat ($urandom_range(1, 40)) @(negedge i_clk);
                end else if (r < 90) begin
                    i_out_ready <= 1'b0;
                    repeat ($urandom_range(1, 4)) @(negedge i_clk);
                end else if (r < 98) begin
                    i_out_ready <= 1'b0;
                    repeat ($urandom_range(5, 30)) @(negedge i_clk);
                end else begin
                    i_out_ready <= 1'b0;
                    repeat ($urandom_range(100, 600)) @(negedge i_clk);
                end
            end
        end
    end

    initial begin
        #60_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        logic [FIELD_W-1:0] m;
        int                 waited;
        int                 n_words;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // modulus still at its reset value of one
        apb_access(1'b0, '0);
        send_word(32'd7, '0);
        send_word('0, '0);
        send_word(ALL_ONES, ALL_ONES);
        send_word(32'd5, 32'd1);

        set_modulus(PRIME_MAX);
        send_word('0, '0);
        send_word('0, 32'd1);
        send_word('0, ALL_ONES);
        send_word(32'd1, ALL_ONES);
        send_word(ALL_ONES, 32'd1);
        send_word(ALL_ONES, ALL_ONES);
        send_word(32'd2, 32'd31);
        send_word(32'd2, 32'd32);
        send_word(32'd3, 32'h8000_0000);
        send_word(PRIME_MAX, 32'd3);
        send_word(PRIME_MAX - 1, 32'd2);

        set_modulus(ALL_ONES);
        send_word(ALL_ONES - 1, ALL_ONES);
        send_word(32'h1234_5678, 32'd2);
        send_word(ALL_ONES, 32'd5);

        // zero modulus wraps products to the field width
        set_modulus('0);
        send_word(ALL_ONES, ALL_ONES);
        send_word(32'd3, 32'd40);
        send_word(32'h8000_0000, 32'd2);

        set_modulus(32'd2);
        send_word(32'hAAAA_AAAA, 32'h5555_5555);
        send_word(32'h5555_5555, 32'hAAAA_AAAA);

        // back-to-back words while the output side holds off, so the input stalls
        set_modulus(32'd65537);
        hold_off_req = 1'b1;
        no_gaps = 1'b1;
        for (int k = 0; k < 8; k++)
            send_word($urandom, $urandom_range(1, 63));
        no_gaps = 1'b0;

        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: m = $urandom | 32'h8000_0000;
                1: m = $urandom_range(2, 1000);
                2: m = $urandom_range(46341, 70000);
                3: m = $urandom;
                4: m = 32'h7FFF_FFFF;
                5: m = '0;
                default: m = 32'd1;
            endcase
            no_gaps = (ph == 2);
            set_modulus(m);
            n_words = (ph == 6) ? 10 : 38;
            for (int k = 0; k < n_words; k++)
                send_word(pick_base(), pick_exponent());
        end
        no_gaps = 1'b0;

        i_in_valid <= 1'b0;
        waited = 0;
        while (pending != 0 && waited < 300000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (200) @(negedge i_clk);

        if (pending != 0)
            $error("result: %0d words never arrived", pending);
        if (mismatches == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
